FILE: hdl/synth_divider_and_multiplier_solver_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the divider and multiplier solver
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SYNTH_DIVIDER_AND_MULTIPLIER_SOLVER_MACROS_SVH
`define SYNTH_DIVIDER_AND_MULTIPLIER_SOLVER_MACROS_SVH
`ifndef SYNTHESIS
// Assert a condition on every rising clock edge outside reset
`define SDMS_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("sdms assertion failed");
// Assert an implication on every rising clock edge outside reset
`define SDMS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sdms implication failed");
`else
`define SDMS_ASSERT(lbl, cond)
`define SDMS_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

FILE: hdl/sdms_pkg.sv
// ----------------------------------------------------------------------------
// sdms_pkg
// Types, constants and the divider table of the divider and multiplier solver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package sdms_pkg;

  // Frequencies in MHz with 21 fractional bits
  localparam logic [33:0] DCO_MIN  = 34'(64'd4850 * 64'h200000);
  localparam logic [33:0] DCO_MAX  = 34'(64'd5670 * 64'h200000);
  localparam logic [33:0] DCO_MID  = 34'(64'd5260 * 64'h200000);
  localparam logic [28:0] FOUT_MIN = 29'(64'd4 * 64'h200000);
  localparam logic [28:0] FOUT_MAX = 29'(64'd160 * 64'h200000);

  localparam logic [31:0] START_WORD = 32'h070A3D71;
  localparam logic [31:0] XTAL_RESET = 32'd1917321216;
  localparam logic [13:0] PPM_RESET  = 14'd3500;
  localparam logic [9:0]  N1_LIMIT   = 10'd128;
  localparam logic [9:0]  RINT_MAX   = 10'd1023;
  localparam logic [27:0] RFRAC_MAX  = 28'hFFFFFFF;
  localparam logic [19:0] PPM_SCALE  = 20'd1000000;

  // Shared unit iteration counts
  localparam logic [6:0] MUL_STEPS    = 7'd20;
  localparam logic [6:0] SRCH_STEPS   = 7'd34;
  localparam logic [6:0] RFREQ_STEPS  = 7'd65;
  localparam logic [2:0] LAST_DIV_IDX = 3'd5;

  // Register indexes
  localparam logic REG_XTAL = 1'b0;
  localparam logic REG_PPM  = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RUN, ST_T1, ST_T2, ST_T3, ST_T4, ST_T5, ST_T6,
    ST_S1, ST_S2, ST_S3, ST_S4, ST_S5, ST_RF, ST_R2, ST_OUT
  } state_e;

  // High speed divider candidates in search order
  function automatic logic [3:0] hs_table(input logic [2:0] k);
    logic [3:0] v;
    unique case (k)
      3'd0:    v = 4'd4;
      3'd1:    v = 4'd5;
      3'd2:    v = 4'd6;
      3'd3:    v = 4'd7;
      3'd4:    v = 4'd9;
      3'd5:    v = 4'd11;
      default: v = 4'd4;
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/synth_divider_and_multiplier_solver.sv
// ----------------------------------------------------------------------------
// synth_divider_and_multiplier_solver
// Oscillator divider search and RFREQ computation on one shift/add unit.
// ----------------------------------------------------------------------------
// A repeated request (same word and crystal) is accepted but gives no result.
// A small step and a full search both run on the bit-serial multiply/divide unit
// (one bit a cycle), which the small step uses fewer times than the full search.
// One transaction at a time; in_ready_o is high only while idle.
// Reset (rst_ni low, asynchronous) restores the config registers and solver state.
`timescale 1ns / 1ps
`include "synth_divider_and_multiplier_solver_macros.svh"
module synth_divider_and_multiplier_solver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] freq_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  hs_div_o,
  output logic [7:0]  n1_div_o,
  output logic [9:0]  rfreq_int_o,
  output logic [27:0] rfreq_frac_o,
  output logic [47:0] reg_image_o,
  output logic        small_step_o
);

  sdms_pkg::state_e state_q, state_d, ret_q, ret_d;

  logic [31:0] xtal_q, applied_freq_q, applied_xtal_q, applied_freq_d, applied_xtal_d;
  logic [13:0] ppm_q;
  logic [28:0] fout_q, fout_d;
  logic [33:0] dco_q, dco_d, best_q, best_d;
  logic [3:0]  hs_now_q, hs_now_d;
  logic [7:0]  n1_now_q, n1_now_d, n_q, n_d;
  logic [38:0] test_q, test_d;
  logic [58:0] lhs_q, lhs_d;
  logic [33:0] a_q, a_d;
  logic [2:0]  k_q, k_d;
  logic [9:0]  rint_q, rint_d;
  logic [27:0] rfrac_q, rfrac_d;
  logic        small_q, small_d;

  // Shared unit registers
  logic [64:0] acc_q, acc_d, opa_q, opa_d;
  logic [33:0] opb_q, opb_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        div_q, div_d;

  logic        in_acc, repeat_req, small_ok;
  logic [28:0] fout_clamp;
  logic [38:0] diff;
  logic [64:0] mul_sum;
  logic [34:0] rem_sh, div_rem;
  logic        div_ge;
  logic [9:0]  n_adj;

  assign in_ready_o = (state_q == sdms_pkg::ST_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign repeat_req = (freq_word_i == applied_freq_q) && (xtal_q == applied_xtal_q);

  // Clamp the request to the output range
  always_comb begin
    if (freq_word_i < 32'(sdms_pkg::FOUT_MIN)) begin
      fout_clamp = sdms_pkg::FOUT_MIN;
    end else if (freq_word_i > 32'(sdms_pkg::FOUT_MAX)) begin
      fout_clamp = sdms_pkg::FOUT_MAX;
    end else begin
      fout_clamp = freq_word_i[28:0];
    end
  end

  // Shared unit: shift-add multiply or restoring divide step
  assign mul_sum = acc_q + opa_q;
  assign rem_sh  = {acc_q[33:0], opa_q[64]};
  assign div_ge  = rem_sh >= {1'b0, opb_q};
  assign div_rem = div_ge ? rem_sh - {1'b0, opb_q} : rem_sh;

  assign diff     = (test_q > 39'(dco_q)) ? test_q - 39'(dco_q) : 39'(dco_q) - test_q;
  assign small_ok = (test_q > 39'(sdms_pkg::DCO_MIN)) && (test_q < 39'(sdms_pkg::DCO_MAX))
                    && ({6'd0, lhs_q} < acc_q);
  assign n_adj    = ((opa_q[8:0] > 9'd1) && opa_q[0]) ? 10'(opa_q[8:0]) + 10'd1
                                                      : 10'(opa_q[8:0]);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sdms_pkg::ST_IDLE: if (in_acc && !repeat_req) state_d = sdms_pkg::ST_T1;
      sdms_pkg::ST_RUN:  if (cnt_q == 7'd1) state_d = ret_q;
      sdms_pkg::ST_T1:   state_d = sdms_pkg::ST_RUN;
      sdms_pkg::ST_T2:   state_d = sdms_pkg::ST_RUN;
      sdms_pkg::ST_T3:   state_d = sdms_pkg::ST_T4;
      sdms_pkg::ST_T4:   state_d = sdms_pkg::ST_RUN;
      sdms_pkg::ST_T5:   state_d = sdms_pkg::ST_RUN;
      sdms_pkg::ST_T6:   state_d = small_ok ? sdms_pkg::ST_RF : sdms_pkg::ST_S1;
      sdms_pkg::ST_S1:   state_d = sdms_pkg::ST_RUN;
      sdms_pkg::ST_S2:   state_d = sdms_pkg::ST_RUN;
      sdms_pkg::ST_S3:   state_d = (n_adj > sdms_pkg::N1_LIMIT) ? sdms_pkg::ST_S5
                                                                : sdms_pkg::ST_RUN;
      sdms_pkg::ST_S4:   state_d = sdms_pkg::ST_S5;
      sdms_pkg::ST_S5:   state_d = (k_q == sdms_pkg::LAST_DIV_IDX) ? sdms_pkg::ST_RF
                                                                   : sdms_pkg::ST_S1;
      sdms_pkg::ST_RF:   state_d = (xtal_q == 32'd0) ? sdms_pkg::ST_OUT : sdms_pkg::ST_RUN;
      sdms_pkg::ST_R2:   state_d = sdms_pkg::ST_OUT;
      sdms_pkg::ST_OUT:  if (out_ready_i) state_d = sdms_pkg::ST_IDLE;
      default:           state_d = sdms_pkg::ST_IDLE;
    endcase
  end

  // Datapath and shared unit control
  always_comb begin
    ret_d          = ret_q;
    applied_freq_d = applied_freq_q;
    applied_xtal_d = applied_xtal_q;
    fout_d         = fout_q;
    dco_d          = dco_q;
    best_d         = best_q;
    hs_now_d       = hs_now_q;
    n1_now_d       = n1_now_q;
    n_d            = n_q;
    test_d         = test_q;
    lhs_d          = lhs_q;
    a_d            = a_q;
    k_d            = k_q;
    rint_d         = rint_q;
    rfrac_d        = rfrac_q;
    small_d        = small_q;
    acc_d          = acc_q;
    opa_d          = opa_q;
    opb_d          = opb_q;
    cnt_d          = cnt_q;
    div_d          = div_q;
    unique case (state_q)
      sdms_pkg::ST_IDLE: begin
        if (in_acc && !repeat_req) begin
          applied_freq_d = freq_word_i;
          applied_xtal_d = xtal_q;
          fout_d         = fout_clamp;
        end
      end
      sdms_pkg::ST_RUN: begin
        cnt_d = cnt_q - 7'd1;
        if (div_q) begin
          acc_d = {30'd0, div_rem};
          opa_d = {opa_q[63:0], div_ge};
        end else begin
          if (opb_q[0]) acc_d = mul_sum;
          opa_d = {opa_q[63:0], 1'b0};
          opb_d = {1'b0, opb_q[33:1]};
        end
      end
      sdms_pkg::ST_T1: begin
        acc_d = '0; opa_d = 65'(fout_q); opb_d = 34'(hs_now_q);
        cnt_d = sdms_pkg::MUL_STEPS; div_d = 1'b0; ret_d = sdms_pkg::ST_T2;
      end
      sdms_pkg::ST_T2: begin
        acc_d = '0; opa_d = acc_q; opb_d = 34'(n1_now_q);
        cnt_d = sdms_pkg::MUL_STEPS; div_d = 1'b0; ret_d = sdms_pkg::ST_T3;
      end
      sdms_pkg::ST_T3: test_d = acc_q[38:0];
      sdms_pkg::ST_T4: begin
        acc_d = '0; opa_d = 65'(diff); opb_d = 34'(sdms_pkg::PPM_SCALE);
        cnt_d = sdms_pkg::MUL_STEPS; div_d = 1'b0; ret_d = sdms_pkg::ST_T5;
      end
      sdms_pkg::ST_T5: begin
        lhs_d = acc_q[58:0];
        acc_d = '0; opa_d = 65'(dco_q); opb_d = 34'(ppm_q);
        cnt_d = sdms_pkg::MUL_STEPS; div_d = 1'b0; ret_d = sdms_pkg::ST_T6;
      end
      sdms_pkg::ST_T6: begin
        small_d = small_ok;
        if (small_ok) begin
          dco_d = test_q[33:0];
        end else begin
          best_d = sdms_pkg::DCO_MAX;
          k_d    = 3'd0;
        end
      end
      sdms_pkg::ST_S1: begin
        acc_d = '0; opa_d = 65'(fout_q); opb_d = 34'(sdms_pkg::hs_table(k_q));
        cnt_d = sdms_pkg::MUL_STEPS; div_d = 1'b0; ret_d = sdms_pkg::ST_S2;
      end
      sdms_pkg::ST_S2: begin
        a_d   = acc_q[33:0];
        acc_d = '0; opa_d = {sdms_pkg::DCO_MID, 31'd0}; opb_d = acc_q[33:0];
        cnt_d = sdms_pkg::SRCH_STEPS; div_d = 1'b1; ret_d = sdms_pkg::ST_S3;
      end
      sdms_pkg::ST_S3: begin
        n_d   = n_adj[7:0];
        acc_d = '0; opa_d = 65'(a_q); opb_d = 34'(n_adj);
        cnt_d = sdms_pkg::MUL_STEPS; div_d = 1'b0; ret_d = sdms_pkg::ST_S4;
      end
      sdms_pkg::ST_S4: begin
        // Keep the lowest oscillator frequency above the band floor
        if ((acc_q > 65'(sdms_pkg::DCO_MIN)) && (acc_q < 65'(best_q))) begin
          best_d   = acc_q[33:0];
          n1_now_d = n_q;
          hs_now_d = sdms_pkg::hs_table(k_q);
        end
      end
      sdms_pkg::ST_S5: begin
        if (k_q == sdms_pkg::LAST_DIV_IDX) begin
          dco_d = best_q;
        end else begin
          k_d = k_q + 3'd1;
        end
      end
      sdms_pkg::ST_RF: begin
        if (xtal_q == 32'd0) begin
          rint_d  = sdms_pkg::RINT_MAX;
          rfrac_d = sdms_pkg::RFRAC_MAX;
        end else begin
          acc_d = '0; opa_d = {dco_q, 31'd0}; opb_d = 34'(xtal_q);
          cnt_d = sdms_pkg::RFREQ_STEPS; div_d = 1'b1; ret_d = sdms_pkg::ST_R2;
        end
      end
      sdms_pkg::ST_R2: begin
        // Saturate when the integer part overflows ten bits
        if (opa_q[64:38] != '0) begin
          rint_d  = sdms_pkg::RINT_MAX;
          rfrac_d = sdms_pkg::RFRAC_MAX;
        end else begin
          rint_d  = opa_q[37:28];
          rfrac_d = opa_q[27:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Control and solver state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= sdms_pkg::ST_IDLE;
      ret_q          <= sdms_pkg::ST_IDLE;
      xtal_q         <= sdms_pkg::XTAL_RESET;
      ppm_q          <= sdms_pkg::PPM_RESET;
      applied_freq_q <= sdms_pkg::START_WORD;
      applied_xtal_q <= '0;
      dco_q          <= '0;
      hs_now_q       <= '0;
      n1_now_q       <= '0;
      cnt_q          <= '0;
      div_q          <= 1'b0;
      k_q            <= '0;
    end else begin
      state_q        <= state_d;
      ret_q          <= ret_d;
      applied_freq_q <= applied_freq_d;
      applied_xtal_q <= applied_xtal_d;
      dco_q          <= dco_d;
      hs_now_q       <= hs_now_d;
      n1_now_q       <= n1_now_d;
      cnt_q          <= cnt_d;
      div_q          <= div_d;
      k_q            <= k_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          sdms_pkg::REG_XTAL: xtal_q <= cfg_wdata_i;
          sdms_pkg::REG_PPM:  ppm_q  <= cfg_wdata_i[13:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    fout_q  <= fout_d;
    best_q  <= best_d;
    n_q     <= n_d;
    test_q  <= test_d;
    lhs_q   <= lhs_d;
    a_q     <= a_d;
    rint_q  <= rint_d;
    rfrac_q <= rfrac_d;
    small_q <= small_d;
    acc_q   <= acc_d;
    opa_q   <= opa_d;
    opb_q   <= opb_d;
  end

  // Result outputs
  assign out_valid_o  = (state_q == sdms_pkg::ST_OUT);
  assign hs_div_o     = hs_now_q;
  assign n1_div_o     = n1_now_q;
  assign rfreq_int_o  = rint_q;
  assign rfreq_frac_o = rfrac_q;
  assign small_step_o = small_q;
  assign reg_image_o  = {3'(hs_now_q - 4'd4), 7'(n1_now_q - 8'd1), rint_q, rfrac_q};

  `SDMS_ASSERT_IMP(a_out_blocks_in, out_valid_o, !in_ready_o)
  `SDMS_ASSERT_IMP(a_run_count, state_q == sdms_pkg::ST_RUN, cnt_q != 7'd0)
  `SDMS_ASSERT_IMP(a_search_idx, state_q == sdms_pkg::ST_S1, k_q <= sdms_pkg::LAST_DIV_IDX)

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for synth_divider_and_multiplier_solver
// Drives frequency requests over a valid/ready channel under several crystal
// and ppm settings, predicts divider choice, RFREQ and register image, and
// checks every result transaction against the prediction in order.
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic [3:0]  hs;
    logic [7:0]  n1;
    logic [9:0]  rint;
    logic [27:0] rfrac;
    logic [47:0] image;
    logic        small_flag;
  } solution_t;

  localparam longint unsigned ONE_MHZ  = 64'h200000;
  localparam longint unsigned DCO_LO   = 64'd4850 * ONE_MHZ;
  localparam longint unsigned DCO_HI   = 64'd5670 * ONE_MHZ;
  localparam longint unsigned DCO_CTR  = 64'd5260 * ONE_MHZ;
  localparam longint unsigned REQ_LO   = 64'd4 * ONE_MHZ;
  localparam longint unsigned REQ_HI   = 64'd160 * ONE_MHZ;
  localparam int              STALL_LIMIT = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_addr_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] freq_word_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [3:0]  hs_div_o;
  logic [7:0]  n1_div_o;
  logic [9:0]  rfreq_int_o;
  logic [27:0] rfreq_frac_o;
  logic [47:0] reg_image_o;
  logic        small_step_o;

  synth_divider_and_multiplier_solver dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Solver state mirror
  logic [31:0]     xtal_cfg, ppm_cfg, last_req, last_xtal;
  longint unsigned dco_cur;
  logic [7:0]      hs_cur, n1_cur;
  byte unsigned    hs_choices [6] = '{8'd4, 8'd5, 8'd6, 8'd7, 8'd9, 8'd11};

  logic [31:0] request_q [$];
  solution_t   solution_q [$];
  int          errors = 0, n_results = 0, n_small = 0, n_quiet = 0;
  logic        burst_mode = 1'b0;
  logic        in_taken = 1'b0, out_taken = 1'b0;
  int          in_gap = 0, out_stall = 0, idle_cycles = 0;

  // Solve one request; push a solution when the request is new
  function automatic void solve_request(input logic [31:0] word);
    longint unsigned fout, trial, diff, best, a, n, num, ip, rem, f;
    logic [31:0] ri, rf;
    logic [7:0]  hs_m4, n1_m1;
    logic        is_small;
    solution_t   s;
    if (word == last_req && xtal_cfg == last_xtal) begin
      n_quiet++;
      return;
    end
    last_req  = word;
    last_xtal = xtal_cfg;
    fout = word;
    if (fout < REQ_LO) fout = REQ_LO;
    if (fout > REQ_HI) fout = REQ_HI;
    trial = fout * hs_cur * n1_cur;
    diff = (trial > dco_cur) ? trial - dco_cur : dco_cur - trial;
    is_small = trial > DCO_LO && trial < DCO_HI &&
               diff * 64'd1000000 < dco_cur * longint'(ppm_cfg);
    if (is_small) begin
      dco_cur = trial;
    end else begin
      best = DCO_HI;
      for (int k = 0; k < 6; k++) begin
        a = fout * hs_choices[k];
        n = DCO_CTR / a;
        if (n > 1 && n[0]) n++;
        if (n <= 128) begin
          trial = a * n;
          if (trial > DCO_LO && trial < best) begin
            best   = trial;
            n1_cur = n[7:0];
            hs_cur = hs_choices[k];
          end
        end
      end
      dco_cur = best;
    end
    // RFREQ in 10.28, saturated
    ri = 32'd1023;
    rf = 32'h0FFFFFFF;
    if (xtal_cfg != 0) begin
      num = dco_cur << 3;
      ip  = num / xtal_cfg;
      rem = num % xtal_cfg;
      if (ip <= 1023) begin
        f = (rem * 64'h10000000) / xtal_cfg;
        if (f > 64'h0FFFFFFF) f = 64'h0FFFFFFF;
        ri = ip[31:0];
        rf = f[31:0];
      end
    end
    hs_m4 = hs_cur - 8'd4;
    n1_m1 = n1_cur - 8'd1;
    s.hs         = hs_cur[3:0];
    s.n1         = n1_cur;
    s.rint       = ri[9:0];
    s.rfrac      = rf[27:0];
    s.image      = {hs_m4[2:0], n1_m1[6:0], ri[9:0], rf[27:0]};
    s.small_flag = is_small;
    if (is_small) n_small++;
    solution_q.push_back(s);
  endfunction

  // Drive requests at the falling edge with random gaps
  always @(negedge clk_i) begin
    logic        nv;
    logic [31:0] nd;
    nv = in_valid_i;
    nd = freq_word_i;
    if (!rst_ni) begin
      nv = 1'b0;
    end else if (!in_valid_i || in_taken) begin
      nv = 1'b0;
      if (in_gap != 0) begin
        in_gap--;
      end else if (request_q.size() != 0) begin
        nv = 1'b1;
        nd = request_q.pop_front();
        in_gap = burst_mode ? 0 : $urandom_range(0, 13);
      end
    end
    in_valid_i  <= nv;
    freq_word_i <= nd;
  end

  // Hold off the result channel for a random stall per transaction
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_taken) out_stall = burst_mode ? 0 : $urandom_range(0, 13);
      else if (out_stall != 0) out_stall--;
      out_ready_i <= (out_stall == 0);
    end
  end

  // Monitor both channels at the rising edge
  always @(posedge clk_i) begin
    solution_t s;
    in_taken  <= in_valid_i && in_ready_o;
    out_taken <= out_valid_o && out_ready_i;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) solve_request(freq_word_i);
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (solution_q.size() == 0) begin
          $error("result transaction with no request pending");
          errors++;
        end else begin
          s = solution_q.pop_front();
          if (hs_div_o !== s.hs) begin
            $error("hs_div: expected %0d, got %0d", s.hs, hs_div_o); errors++;
          end
          if (n1_div_o !== s.n1) begin
            $error("n1_div: expected %0d, got %0d", s.n1, n1_div_o); errors++;
          end
          if (rfreq_int_o !== s.rint) begin
            $error("rfreq_int: expected %0d, got %0d", s.rint, rfreq_int_o); errors++;
          end
          if (rfreq_frac_o !== s.rfrac) begin
            $error("rfreq_frac: expected %h, got %h", s.rfrac, rfreq_frac_o); errors++;
          end
          if (reg_image_o !== s.image) begin
            $error("reg_image: expected %h, got %h", s.image, reg_image_o); errors++;
          end
          if (small_step_o !== s.small_flag) begin
            $error("small_step: expected %0d, got %0d", s.small_flag, small_step_o);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("synth_divider_and_multiplier_solver: mismatch");
      $finish;
    end
  end

  task automatic write_reg(input logic addr, input logic [31:0] value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (addr == sdms_pkg::REG_XTAL) xtal_cfg = value;
    else ppm_cfg = {18'd0, value[13:0]};
    @(negedge clk_i);
  endtask

  task automatic drain();
    while (request_q.size() != 0 || in_valid_i || solution_q.size() != 0)
      @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_request(input logic [31:0] prev);
    int unsigned sel;
    logic [31:0] step;
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      // nudge the previous request to aim at the small-step path
      step = prev >> $urandom_range(7, 16);
      return $urandom_range(0, 1) ? prev + step : prev - step;
    end
    if (sel < 45) return prev;
    if (sel < 65) return $urandom;
    return $urandom_range(32'd4 << 21, 32'd160 << 21);
  endfunction

  task automatic run_phase(input logic [31:0] xtal, input logic [31:0] ppm,
                           input int count);
    logic [31:0] w;
    write_reg(sdms_pkg::REG_XTAL, xtal);
    write_reg(sdms_pkg::REG_PPM, ppm);
    burst_mode = ($urandom_range(0, 3) == 0);
    w = $urandom_range(32'd10 << 21, 32'd150 << 21);
    for (int i = 0; i < count; i++) begin
      w = pick_request(w);
      request_q.push_back(w);
    end
    drain();
  endtask

  initial begin
    logic [31:0] directed [$];
    xtal_cfg = sdms_pkg::XTAL_RESET; ppm_cfg = 32'(sdms_pkg::PPM_RESET);
    last_req = sdms_pkg::START_WORD; last_xtal = '0;
    dco_cur = 0; hs_cur = '0; n1_cur = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: start word, clamps, repeats, small and large moves
    directed = '{sdms_pkg::START_WORD, sdms_pkg::START_WORD, 32'h0, 32'hFFFFFFFF,
                 32'd4 << 21, (32'd4 << 21) - 1, 32'd160 << 21, (32'd160 << 21) + 1,
                 32'd160 << 21, 32'd100 << 21, (32'd100 << 21) + 32'd1000,
                 (32'd100 << 21) + 32'd1000, (32'd100 << 21) - 32'd50000,
                 32'd14 << 21, 32'd7 << 21, 32'd56 << 21, 32'h55555555,
                 32'hAAAAAAAA, 32'd33 << 21};
    foreach (directed[i]) request_q.push_back(directed[i]);
    drain();

    // Same word across a crystal change must solve again
    write_reg(sdms_pkg::REG_XTAL, 32'd0);
    request_q.push_back(32'd33 << 21);
    request_q.push_back(32'd33 << 21);
    drain();

    run_phase(sdms_pkg::XTAL_RESET, 32'(sdms_pkg::PPM_RESET), 400);
    run_phase(32'd0, 32'd10000, 150);
    run_phase(32'hFFFFFFFF, 32'd0, 200);
    run_phase(32'd1, 32'h3FFF, 150);
    run_phase(32'h72000000 + $urandom_range(0, 32'hFFFFFF), 32'd1000, 400);
    run_phase($urandom, $urandom_range(0, 10000), 250);
    run_phase(32'h59000000, 32'd10000, 300);

    $display("Covered %0d solver results (%0d small steps), %0d repeated requests,",
             n_results, n_small, n_quiet);
    $display("over seven crystal and ppm settings including zero and full scale.");
    if (errors == 0) begin
      $display("synth_divider_and_multiplier_solver: match");
    end else begin
      $display("synth_divider_and_multiplier_solver: mismatch");
    end
    $finish;
  end
endmodule
